[rtl/core/ppv_pkg.sv]
// ----------------------------------------------------------------------------
// ppv_pkg
// shared types and constants of the perspective projection viewport block
// ----------------------------------------------------------------------------
package ppv_pkg;

  localparam int unsigned FRAME_WIDTH_DEF  = 608;
  localparam int unsigned FRAME_HEIGHT_DEF = 448;

  localparam logic [2:0] REG_VIEW_PRESENT    = 3'd0;
  localparam logic [2:0] REG_VIEWPORT_X      = 3'd1;
  localparam logic [2:0] REG_VIEWPORT_Y      = 3'd2;
  localparam logic [2:0] REG_VIEWPORT_WIDTH  = 3'd3;
  localparam logic [2:0] REG_VIEWPORT_HEIGHT = 3'd4;

  localparam logic MODE_LOAD    = 1'b0;
  localparam logic MODE_PROJECT = 1'b1;

  localparam logic signed [19:0] BIG_SCALE = 20'sd500000;

  // divider request and reply
  typedef struct packed {
    logic               start;
    logic signed [63:0] num;
    logic signed [31:0] den;
  } div_req_t;

  typedef struct packed {
    logic               done;
    logic signed [63:0] quo;
  } div_rsp_t;

  function automatic logic signed [31:0] sat32(input logic signed [71:0] v);
    if (v > 72'sd2147483647) return 32'sh7fffffff;
    if (v < -72'sd2147483648) return 32'sh80000000;
    return v[31:0];
  endfunction

endpackage

[rtl/core/ppv_div.sv]
// ----------------------------------------------------------------------------
// ppv_div
// radix-2 restoring divider, signed, truncating toward zero, one bit a cycle
// ----------------------------------------------------------------------------
module ppv_div (
  input  logic             clk,
  input  logic             rst,
  input  ppv_pkg::div_req_t req,
  output ppv_pkg::div_rsp_t rsp
);

  logic        busy;
  logic        fin;
  logic [6:0]  cnt;
  logic [63:0] quo;
  logic [64:0] rem;
  logic [31:0] dmag;
  logic        neg;
  logic [64:0] trial;

  assign trial = {rem[63:0], quo[63]} - {33'd0, dmag};

  // shift-subtract loop
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      fin  <= 1'b0;
      cnt  <= '0;
    end else begin
      fin <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        cnt  <= 7'd0;
        quo  <= req.num[63] ? 64'(-req.num) : 64'(req.num);
        dmag <= req.den[31] ? 32'(-req.den) : 32'(req.den);
        neg  <= req.num[63] ^ req.den[31];
        rem  <= '0;
      end else if (busy) begin
        if (!trial[64]) begin
          rem <= trial;
          quo <= {quo[62:0], 1'b1};
        end else begin
          rem <= {rem[63:0], quo[63]};
          quo <= {quo[62:0], 1'b0};
        end
        cnt <= cnt + 7'd1;
        if (cnt == 7'd63) begin
          busy <= 1'b0;
          fin  <= 1'b1;
        end
      end
    end
  end

  assign rsp.done = fin;
  assign rsp.quo  = neg ? 64'(-$signed(quo)) : $signed(quo);

endmodule

[rtl/core/ppv_seq.sv]
// ----------------------------------------------------------------------------
// ppv_seq
// sequencer around one shared 32x32 multiplier and the divider
// ----------------------------------------------------------------------------
module ppv_seq #(
  parameter int unsigned FRAME_WIDTH  = ppv_pkg::FRAME_WIDTH_DEF,
  parameter int unsigned FRAME_HEIGHT = ppv_pkg::FRAME_HEIGHT_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic               view_present,
  input  logic [11:0]        viewport_x,
  input  logic [11:0]        viewport_y,
  input  logic [11:0]        viewport_width,
  input  logic [11:0]        viewport_height,
  input  logic signed [31:0] px,
  input  logic signed [31:0] py,
  input  logic signed [31:0] pz,
  output logic [3:0]         mat_addr,
  input  logic signed [31:0] mat_data,
  output ppv_pkg::div_req_t  dreq,
  input  ppv_pkg::div_rsp_t  drsp,
  output logic               done,
  output logic signed [31:0] sx,
  output logic signed [31:0] sy,
  output logic signed [31:0] dep
);

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_DOT  = 4'd1;
  localparam logic [3:0] S_MUL  = 4'd2;
  localparam logic [3:0] S_ACC  = 4'd3;
  localparam logic [3:0] S_DIV  = 4'd4;
  localparam logic [3:0] S_DWT  = 4'd5;
  localparam logic [3:0] S_VP   = 4'd6;
  localparam logic [3:0] S_VPM  = 4'd7;
  localparam logic [3:0] S_VPA  = 4'd8;
  localparam logic [3:0] S_DONE = 4'd9;
  localparam logic [3:0] S_VPH  = 4'd10;

  localparam logic signed [47:0] HALF_W = 48'sd65536 * 48'(FRAME_WIDTH / 2);
  localparam logic signed [47:0] HALF_H = 48'sd65536 * 48'(FRAME_HEIGHT / 2);

  logic [3:0]         state;
  logic [3:0]         idx;
  logic [1:0]         dsel;
  logic               vsel;
  logic signed [49:0] acc;
  logic signed [31:0] vx, vy, vz, w;
  logic signed [63:0] hi_p;
  logic signed [63:0] tx, ty, dp;
  logic signed [31:0] ma, mb;
  logic signed [63:0] prod;
  logic signed [31:0] rowsum;
  logic signed [31:0] vz_c;
  logic signed [31:0] coord;
  logic signed [47:0] off;
  logic signed [31:0] size;
  logic signed [64:0] tsel;
  logic               use_div;

  assign mat_addr = idx;
  assign rowsum   = ppv_pkg::sat32(72'(acc + 50'(mat_data)));
  assign vz_c     = (vz > 0) ? 32'sd0 : vz;
  assign use_div  = (w > 0) || (w != 0 && dsel == 2'd0);

  always_comb begin
    case (idx[1:0])
      2'd0:    coord = px;
      2'd1:    coord = py;
      default: coord = pz;
    endcase
  end

  // viewport offset and size for the current axis
  always_comb begin
    if (!vsel) begin
      size = (viewport_x != 0) ? 32'(FRAME_WIDTH) : 32'({20'd0, viewport_width});
      off  = (viewport_x != 0) ?
             48'sd32768 * 48'({35'd0, viewport_x, 1'b0} + 48'(viewport_width)) - HALF_W
             : 48'sd0;
      tsel = 65'(tx) + 65'sd32768;
    end else begin
      size = (viewport_y != 0) ? 32'(FRAME_HEIGHT) : 32'({20'd0, viewport_height});
      off  = (viewport_y != 0) ?
             48'sd32768 * 48'({35'd0, viewport_y, 1'b0} + 48'(viewport_height)) - HALF_H
             : 48'sd0;
      tsel = 65'(ty) + 65'sd32768;
    end
  end

  // shared multiplier, registered
  always_ff @(posedge clk) begin
    prod <= ma * mb;
  end

  always_comb begin
    dreq.start = 1'b0;
    dreq.num   = '0;
    dreq.den   = w;
    if (state == S_DIV && use_div) begin
      dreq.start = 1'b1;
      case (dsel)
        2'd0:    dreq.num = 64'(vz_c) * 64'sd32768;
        2'd1:    dreq.num = 64'(vx) * 64'sd32768;
        default: dreq.num = 64'(vy) * 64'sd32768;
      endcase
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      case (state)
        S_IDLE: begin
          if (start) begin
            idx <= '0;
            acc <= '0;
            state <= view_present ? S_DOT : S_DONE;
            if (!view_present) begin
              sx <= '0; sy <= '0; dep <= '0;
            end
          end
        end
        S_DOT: begin
          if (idx[1:0] == 2'd3) begin
            case (idx[3:2])
              2'd0:    vx <= rowsum;
              2'd1:    vy <= rowsum;
              2'd2:    vz <= rowsum;
              default: w  <= rowsum;
            endcase
            acc <= '0;
            idx <= idx + 4'd1;
            if (idx == 4'd15) state <= S_DIV;
            dsel <= 2'd0;
          end else begin
            ma <= mat_data;
            mb <= coord;
            state <= S_MUL;
          end
        end
        S_MUL: state <= S_ACC;
        S_ACC: begin
          acc <= acc + 50'(prod >>> 16);
          idx <= idx + 4'd1;
          state <= S_DOT;
        end
        S_DIV: begin
          if (use_div) state <= S_DWT;
          else begin
            // big scale path for the remaining terms
            if (dsel == 2'd0) dp <= 64'(vz_c) * 64'(ppv_pkg::BIG_SCALE);
            tx <= 64'(vx) * 64'(ppv_pkg::BIG_SCALE);
            ty <= -(64'(vy) * 64'(ppv_pkg::BIG_SCALE));
            vsel  <= 1'b0;
            state <= S_VP;
          end
        end
        S_DWT: begin
          if (drsp.done) begin
            case (dsel)
              2'd0:    dp <= drsp.quo;
              2'd1:    tx <= drsp.quo;
              default: ty <= -drsp.quo;
            endcase
            if (dsel == 2'd2 || (dsel == 2'd0 && !(w > 0))) begin
              if (dsel == 2'd2) begin
                vsel <= 1'b0;
                state <= S_VP;
              end else begin
                dsel <= 2'd1;
                state <= S_DIV;
              end
            end else begin
              dsel <= dsel + 2'd1;
              state <= S_DIV;
            end
          end
        end
        S_VP: begin
          // upper part of the scaled term, split at bit 31
          ma <= tsel[62:31];
          mb <= size;
          state <= S_VPM;
        end
        S_VPM: begin
          // lower 31 bits, kept non-negative
          ma <= {1'b0, tsel[30:0]};
          state <= S_VPH;
        end
        S_VPH: begin
          hi_p <= prod;
          state <= S_VPA;
        end
        S_VPA: begin
          if (!vsel) begin
            sx <= ppv_pkg::sat32((72'(hi_p) <<< 31) + 72'(prod) + 72'(off));
            vsel <= 1'b1;
            state <= S_VP;
          end else begin
            sy <= ppv_pkg::sat32((72'(hi_p) <<< 31) + 72'(prod) + 72'(off));
            dep <= ppv_pkg::sat32(72'(dp));
            state <= S_DONE;
          end
        end
        S_DONE: begin
          done  <= 1'b1;
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  no_div_when_idle: assert property (@(posedge clk) disable iff (rst)
    state == S_IDLE |-> !dreq.start) else $error("divider started while idle");
  done_one_cycle: assert property (@(posedge clk) disable iff (rst)
    done |=> !done) else $error("done held");
  done_when_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> state == S_IDLE) else $error("done outside idle");

endmodule

[rtl/core/perspective_project_viewport_top.sv]
// ----------------------------------------------------------------------------
// perspective_project_viewport_top
// projects Q16.16 points through a loaded 4x4 matrix and a viewport
// ----------------------------------------------------------------------------
// A load word (mode 0) writes one matrix coefficient. A project word (mode 1)
// runs twelve multiply steps (S_DOT, S_MUL, S_ACC) plus four column-3 adds on
// a single shared multiplier, then up to three divisions by w on a bit-serial
// divider, then the viewport states S_VP, S_VPM, S_VPH and S_VPA for x and
// again for y. Zero w needs no division, negative w one and positive w three.
// With no view present the sequencer goes straight to its done state and
// returns zeros. s_tready is low while a point is in flight; the result sits in
// an output register until taken.
module perspective_project_viewport_top #(
  parameter int unsigned FRAME_WIDTH  = ppv_pkg::FRAME_WIDTH_DEF,
  parameter int unsigned FRAME_HEIGHT = ppv_pkg::FRAME_HEIGHT_DEF
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  input  logic [135:0] s_tdata,  // coef_index, coef_value, point_x, point_y, point_z
  input  logic         s_tuser,  // mode
  output logic         m_tvalid,
  input  logic         m_tready,
  output logic [95:0]  m_tdata,  // screen_x, screen_y, depth
  input  logic         cfg_we,
  input  logic [2:0]   cfg_index,
  input  logic [11:0]  cfg_data
);

  logic        view_present;
  logic [11:0] viewport_x, viewport_y, viewport_width, viewport_height;
  logic signed [31:0] matrix [16];
  logic signed [31:0] px, py, pz;
  logic [3:0]  mat_addr;
  logic        busy, start, done;
  logic signed [31:0] sx, sy, dep;
  ppv_pkg::div_req_t dreq;
  ppv_pkg::div_rsp_t drsp;

  assign s_tready = !busy && !m_tvalid;
  assign start    = s_tvalid && s_tready && (s_tuser == ppv_pkg::MODE_PROJECT);

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      view_present    <= 1'b0;
      viewport_x      <= '0;
      viewport_y      <= '0;
      viewport_width  <= 12'd608;
      viewport_height <= 12'd448;
    end else if (cfg_we) begin
      case (cfg_index)
        ppv_pkg::REG_VIEW_PRESENT:    view_present    <= cfg_data[0];
        ppv_pkg::REG_VIEWPORT_X:      viewport_x      <= cfg_data;
        ppv_pkg::REG_VIEWPORT_Y:      viewport_y      <= cfg_data;
        ppv_pkg::REG_VIEWPORT_WIDTH:  viewport_width  <= cfg_data;
        ppv_pkg::REG_VIEWPORT_HEIGHT: viewport_height <= cfg_data;
        default: ;
      endcase
    end
  end

  // matrix and point capture
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 16; i++) matrix[i] <= '0;
    end else if (s_tvalid && s_tready && s_tuser == ppv_pkg::MODE_LOAD) begin
      matrix[s_tdata[3:0]] <= s_tdata[35:4];
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      px <= s_tdata[67:36];
      py <= s_tdata[99:68];
      pz <= s_tdata[131:100];
    end
  end

  // busy flag and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      busy     <= 1'b0;
      m_tvalid <= 1'b0;
    end else begin
      if (start) busy <= 1'b1;
      if (done) begin
        busy     <= 1'b0;
        m_tvalid <= 1'b1;
        m_tdata  <= {dep, sy, sx};
      end else if (m_tvalid && m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  ppv_seq #(.FRAME_WIDTH(FRAME_WIDTH), .FRAME_HEIGHT(FRAME_HEIGHT)) u_seq (
    .clk, .rst, .start, .view_present, .viewport_x, .viewport_y,
    .viewport_width, .viewport_height, .px, .py, .pz,
    .mat_addr, .mat_data(matrix[mat_addr]), .dreq, .drsp, .done, .sx, .sy, .dep
  );

  ppv_div u_div (.clk, .rst, .req(dreq), .rsp(drsp));

  no_accept_busy: assert property (@(posedge clk) disable iff (rst)
    busy |-> !s_tready) else $error("accept while busy");
  done_needs_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> busy) else $error("result without item");
  result_held: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid) else $error("result dropped");

endmodule
